// ----- rtl/core/sli_pkg.sv -----
// Shared constants and types for the sorted list insert block.
`timescale 1ns / 1ps

package sli_pkg;

  localparam int DEPTH   = 1024;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // One result as it leaves the sequencer.
  typedef struct packed {
    data_t              entry;
    logic               entry_valid;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } res_t;

  // Memory access for one cycle: one write and one read address.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr;
  } ram_req_t;

endpackage

// ----- rtl/core/sli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/sli_seq.sv -----
// Sequencer: scans the store from the top, shifts entries >= value up, places it.
`timescale 1ns / 1ps

module sli_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  sli_pkg::data_t   value,
  input  logic [sli_pkg::INDEX_W-1:0] index,
  input  logic             out_free,
  output logic             res_valid,
  output sli_pkg::res_t    res,
  output sli_pkg::ram_req_t ram_req,
  input  sli_pkg::data_t   rdata
);
  import sli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_RDWAIT,
    S_EMIT
  } state_t;

  state_t state;
  addr_t  pos;     // address whose read data arrives this cycle
  data_t  val;     // value being inserted
  cnt_t   cnt;

  logic   accept;
  logic   idx_ok;
  logic   not_below;

  assign accept    = in_valid && in_ready;
  assign idx_ok    = CMP_W'(index) < CMP_W'(cnt);
  assign not_below = !(rdata < val);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_EMIT) && out_free;

  always_comb begin
    ram_req       = '0;
    ram_req.wdata = val;
    unique case (state)
      S_IDLE: begin
        if (action == ACT_READ) begin
          ram_req.raddr = ADDR_W'(index);
        end else begin
          ram_req.raddr = ADDR_W'(cnt - CNT_W'(1));
        end
      end
      S_SHIFT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos + ADDR_W'(1);
        ram_req.raddr = pos - ADDR_W'(1);
        if (not_below) begin
          ram_req.wdata = rdata;
        end
      end
      S_PLACE: begin
        ram_req.we = 1'b1;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pos   <= '0;
      val   <= '0;
      res   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val <= value;
            pos <= ADDR_W'(cnt - CNT_W'(1));
            res <= '{entry: '0, entry_valid: 1'b0, count: COUNT_W'(cnt),
                     dropped: (action == ACT_INSERT) && (cnt == CNT_W'(DEPTH))};
            if (action == ACT_READ) begin
              state <= idx_ok ? S_RDWAIT : S_EMIT;
            end else if (cnt == CNT_W'(DEPTH)) begin
              state <= S_EMIT;
            end else if (cnt == '0) begin
              state <= S_PLACE;
            end else begin
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (not_below) begin
            // entry moved up; stop at the bottom and place at the front
            if (pos == '0) begin
              state <= S_PLACE;
            end else begin
              pos <= pos - ADDR_W'(1);
            end
          end else begin
            cnt       <= cnt + CNT_W'(1);
            res.count <= COUNT_W'(cnt + CNT_W'(1));
            state     <= S_EMIT;
          end
        end
        S_PLACE: begin
          cnt       <= cnt + CNT_W'(1);
          res.count <= COUNT_W'(cnt + CNT_W'(1));
          state     <= S_EMIT;
        end
        S_RDWAIT: begin
          res.entry       <= rdata;
          res.entry_valid <= 1'b1;
          state           <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/sorted_list_insert.sv -----
// Sorted list insert: ordered store of up to 1024 signed 32-bit values in one RAM,
// filled by inserts and read back by index. Each request gives one result with the
// count after it. A valid read passes through a read-wait state before the emit state;
// an invalid read or a refused insert goes straight to the emit state. An insert
// moves up every stored entry not smaller than the new value: the sequencer walks
// down from the top entry, moving one entry up a place per cycle through the single
// read and single write port of the RAM, then writes the value.
// One request is in work at a time; the next is taken the cycle after the result is
// loaded, while that result may still wait in the output register. A finished result
// holds the sequencer until the output register is free.
`timescale 1ns / 1ps

module sorted_list_insert (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic signed [31:0]          value,
  input  logic [sli_pkg::INDEX_W-1:0] index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          entry,
  output logic                        entry_valid,
  output logic [sli_pkg::COUNT_W-1:0] count,
  output logic                        dropped
);
  import sli_pkg::*;

  ram_req_t ram_req;
  data_t    rdata;
  logic     out_free;
  logic     res_valid;
  res_t     res;

  assign out_free = !out_valid || out_ready;

  sli_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(rdata)
  );

  sli_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .value    (value),
    .index    (index),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res),
    .ram_req  (ram_req),
    .rdata    (rdata)
  );

  // Output register: load a new result, or drop the old one once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      entry       <= res.entry;
      entry_valid <= res.entry_valid;
      count       <= res.count;
      dropped     <= res.dropped;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count <= COUNT_W'(DEPTH)))
    else $error("result count exceeds store depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> (count == COUNT_W'(DEPTH)))
    else $error("insert dropped while store not full");

  a_drop_no_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> !entry_valid && (entry == '0))
    else $error("dropped insert carries an entry");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule

// ----- verif/sorted_list_insert_tb.sv -----
// Testbench for the sorted list insert block: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module sorted_list_insert_tb;
  import sli_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic signed [31:0] value;
  logic [INDEX_W-1:0] index;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] entry;
  logic               entry_valid;
  logic [COUNT_W-1:0] count;
  logic               dropped;

  data_t model_store [DEPTH];
  int    model_count = 0;
  res_t  pending_results [$];
  int    mismatches = 0;
  bit    steady = 1'b0;

  sorted_list_insert dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Predict one result and apply the request to the sorted model.
  function automatic res_t predict_result(action_t act, data_t val, logic [INDEX_W-1:0] idx);
    res_t r;
    int   pos;
    r = '0;
    if (act == ACT_INSERT) begin
      if (model_count >= DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        pos = 0;
        // land before any equal entries
        while (pos < model_count && model_store[pos] < val) pos++;
        for (int j = model_count; j > pos; j--) model_store[j] = model_store[j-1];
        model_store[pos] = val;
        model_count++;
      end
    end else if (idx < model_count) begin
      r.entry       = model_store[idx];
      r.entry_valid = 1'b1;
    end
    r.count = model_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic data_t pick_corner();
    case ($urandom_range(0, 6))
      0:       return 32'sh8000_0000;
      1:       return 32'sh8000_0001;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4:       return 32'sd1;
      5:       return 32'sh7FFF_FFFE;
      default: return 32'sh7FFF_FFFF;
    endcase
  endfunction

  function automatic data_t pick_insert_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return data_t'($urandom);
    if (r < 65) return data_t'(int'($urandom_range(0, 30)) - 15);
    if (r < 80 || model_count == 0) return pick_corner();
    // duplicate an entry already stored
    return model_store[$urandom_range(0, model_count - 1)];
  endfunction

  function automatic logic [INDEX_W-1:0] pick_read_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75 && model_count > 0) return INDEX_W'($urandom_range(0, model_count - 1));
    if (r < 90 && model_count <= DEPTH - 3) return INDEX_W'(model_count + $urandom_range(0, 2));
    return INDEX_W'($urandom);
  endfunction

  // Called right after a rising edge; returns at the edge that accepts the request.
  task automatic send_request(action_t act, data_t val, logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    index    <= idx;
    do @(negedge clk); while (!in_ready);
    pending_results.push_back(predict_result(act, val, idx));
    @(posedge clk);
  endtask

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_checker
    res_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d %0b %0d %0b",
                   $time, entry, entry_valid, count, dropped);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("entry", $signed(want.entry), entry);
          check_field("entry_valid", want.entry_valid, entry_valid);
          check_field("count", want.count, count);
          check_field("dropped", want.dropped, dropped);
        end
      end
    end
  end

  initial begin : out_stall_driver
    int unsigned run_len;
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 24);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic test_empty_and_order();
    send_request(ACT_READ, data_t'($urandom), '0);
    send_request(ACT_READ, data_t'($urandom), 10'h3FF);
    send_request(ACT_INSERT, 32'sd100, INDEX_W'($urandom));
    send_request(ACT_INSERT, -32'sd50, INDEX_W'($urandom));
    send_request(ACT_INSERT, 32'sh8000_0000, INDEX_W'($urandom));
    send_request(ACT_INSERT, 32'sh7FFF_FFFF, INDEX_W'($urandom));
    send_request(ACT_INSERT, 32'sd100, INDEX_W'($urandom));
    send_request(ACT_INSERT, 32'sd0, INDEX_W'($urandom));
    send_request(ACT_INSERT, -32'sd1, INDEX_W'($urandom));
    for (int i = 0; i < 7; i++) send_request(ACT_READ, data_t'($urandom), i[INDEX_W-1:0]);
    // one past the last entry, then the top index
    send_request(ACT_READ, data_t'($urandom), 10'd7);
    send_request(ACT_READ, data_t'($urandom), 10'h3FF);
  endtask

  task automatic test_random_mix(int n_items);
    action_t            act;
    data_t              val;
    logic [INDEX_W-1:0] idx;
    for (int i = 0; i < n_items; i++) begin
      steady = (i < 80) || (i >= 250 && i < 290);
      val = data_t'($urandom);
      idx = INDEX_W'($urandom);
      if ($urandom_range(0, 99) < 55) begin
        act = ACT_INSERT;
        val = pick_insert_value();
      end else begin
        act = ACT_READ;
        idx = pick_read_index();
      end
      send_request(act, val, idx);
    end
    steady = 1'b0;
  endtask

  // Fill with rising values just below the top corners so each insert moves few entries.
  task automatic test_fill_to_capacity();
    data_t next_val;
    next_val = 32'sh7FFF_F000;
    while (model_count < DEPTH) begin
      if ($urandom_range(0, 19) == 0) begin
        send_request(ACT_READ, data_t'($urandom), pick_read_index());
      end else begin
        send_request(ACT_INSERT, next_val, INDEX_W'($urandom));
        next_val++;
      end
    end
  endtask

  task automatic test_full_store(int n_items);
    send_request(ACT_INSERT, 32'sh8000_0000, INDEX_W'($urandom));
    send_request(ACT_INSERT, 32'sh7FFF_FFFF, INDEX_W'($urandom));
    send_request(ACT_READ, data_t'($urandom), '0);
    send_request(ACT_READ, data_t'($urandom), 10'h3FF);
    for (int i = 0; i < n_items; i++) begin
      steady = (i >= 50 && i < 90);
      if ($urandom_range(0, 1) == 0) send_request(ACT_INSERT, pick_insert_value(), INDEX_W'($urandom));
      else send_request(ACT_READ, data_t'($urandom), INDEX_W'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    action   <= ACT_INSERT;
    value    <= '0;
    index    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_order();
    test_random_mix(400);
    test_fill_to_capacity();
    test_full_store(150);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // watch for stray results
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
